[hw/rtl/signed_int_to_decimal_ascii_defines.svh]
// assertion macros for the rtl of the integer to decimal text converter
// no dependencies; included by files that carry concurrent assertions
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SITDA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SITDA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sitda_pkg.sv]
// shared types and constants of the integer to decimal text converter
// no dependencies
`default_nettype none

package sitda_pkg;

    localparam int MAG_W       = 64;
    localparam int DIGITS      = 20;
    localparam int BCD_W       = DIGITS * 4;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int LEN_W       = 5;
    localparam int CHAR_W      = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // one classified number waiting for conversion
    typedef struct packed {
        logic             negative;
        logic [MAG_W-1:0] mag;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/sitda_front.sv]
// front stage: accepts a number, splits it into sign and unsigned magnitude
// depends on sitda_pkg
`default_nettype none

module sitda_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [63:0] s_number,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output sitda_pkg::job_t        job
);

    logic            front_valid_reg;
    logic            front_valid_next;
    sitda_pkg::job_t front_job_reg;
    sitda_pkg::job_t classified;
    logic            s_accept;

    assign s_ready  = !front_valid_reg || job_ready;
    assign s_accept = s_valid && s_ready;

    // two's complement magnitude, the most negative value gives 2^63
    always_comb begin
        classified.negative = s_number[63];
        classified.mag      = s_number[63] ? (~s_number + 64'd1) : s_number;
    end

    always_comb begin
        front_valid_next = front_valid_reg;
        if (s_accept) begin
            front_valid_next = 1'b1;
        end else if (job_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            front_job_reg <= classified;
        end
    end

    assign job_valid = front_valid_reg;
    assign job       = front_job_reg;

endmodule

`default_nettype wire

[hw/rtl/sitda_queue.sv]
// short queue of classified numbers between the front and back stages
// depends on sitda_pkg
`default_nettype none

module sitda_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sitda_pkg::job_t in_job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sitda_pkg::job_t      out_job
);

    sitda_pkg::job_t                 slot_reg [sitda_pkg::QUEUE_DEPTH];
    logic [sitda_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sitda_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [sitda_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sitda_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [sitda_pkg::QCNT_W-1:0]    count_reg;
    logic [sitda_pkg::QCNT_W-1:0]    count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg != sitda_pkg::QCNT_W'(sitda_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sitda_back.sv]
// back stage: bit-serial binary to bcd, leading zero trim, character output
// depends on sitda_pkg and signed_int_to_decimal_ascii_defines.svh
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sitda_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                job_valid,
    output logic                                     job_ready,
    input  wire sitda_pkg::job_t                     job,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sitda_pkg::CHAR_W-1:0]             m_char_code,
    output logic                                     m_is_last,
    output logic [sitda_pkg::LEN_W-1:0]              m_text_length
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_TRIM  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic [sitda_pkg::MAG_W-1:0]        mag_reg, mag_next;
    logic [sitda_pkg::BCD_W-1:0]        bcd_reg, bcd_next;
    logic [sitda_pkg::BCD_W-1:0]        bcd_adj;
    logic                               neg_reg, neg_next;
    logic [sitda_pkg::CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [sitda_pkg::LEN_W-1:0]        ndig_reg, ndig_next;
    logic [sitda_pkg::LEN_W-1:0]        total_reg, total_next;
    logic [3:0]                         top_digit;

    logic                               m_valid_reg, m_valid_next;
    logic [sitda_pkg::CHAR_W-1:0]       m_char_code_reg, m_char_code_next;
    logic                               m_is_last_reg, m_is_last_next;
    logic [sitda_pkg::LEN_W-1:0]        m_text_length_reg, m_text_length_next;
    logic                               out_load;

    assign top_digit = bcd_reg[sitda_pkg::BCD_W-1 -: 4];
    assign out_load  = !m_valid_reg || m_ready;
    assign job_ready = state_reg == ST_IDLE;

    // add-3 correction on every bcd digit of five or more
    always_comb begin
        for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
            bcd_adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ?
                                (bcd_reg[d*4 +: 4] + 4'd3) : bcd_reg[d*4 +: 4];
        end
    end

    always_comb begin
        state_next         = state_reg;
        mag_next           = mag_reg;
        bcd_next           = bcd_reg;
        neg_next           = neg_reg;
        bit_cnt_next       = bit_cnt_reg;
        ndig_next          = ndig_reg;
        total_next         = total_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_char_code_next   = m_char_code_reg;
        m_is_last_next     = m_is_last_reg;
        m_text_length_next = m_text_length_reg;

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    mag_next     = job.mag;
                    neg_next     = job.negative;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_reg[sitda_pkg::MAG_W-1]};
                mag_next     = {mag_reg[sitda_pkg::MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sitda_pkg::CNT_W'(sitda_pkg::MAG_W - 1)) begin
                    ndig_next  = sitda_pkg::LEN_W'(sitda_pkg::DIGITS);
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                // drop one leading zero digit per cycle, keep at least one
                if (top_digit == 4'd0 && ndig_reg != sitda_pkg::LEN_W'(1)) begin
                    bcd_next  = {bcd_reg[sitda_pkg::BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end else begin
                    total_next = ndig_reg + sitda_pkg::LEN_W'(neg_reg);
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_load) begin
                    m_valid_next       = 1'b1;
                    m_char_code_next   = sitda_pkg::CHAR_MINUS;
                    m_is_last_next     = 1'b0;
                    m_text_length_next = '0;
                    state_next         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_load) begin
                    m_valid_next       = 1'b1;
                    m_char_code_next   = sitda_pkg::CHAR_ZERO +
                                         {{(sitda_pkg::CHAR_W-4){1'b0}}, top_digit};
                    m_is_last_next     = ndig_reg == sitda_pkg::LEN_W'(1);
                    m_text_length_next = (ndig_reg == sitda_pkg::LEN_W'(1)) ? total_reg : '0;
                    bcd_next           = {bcd_reg[sitda_pkg::BCD_W-5:0], 4'd0};
                    ndig_next          = ndig_reg - 1'b1;
                    if (ndig_reg == sitda_pkg::LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg           <= mag_next;
        bcd_reg           <= bcd_next;
        neg_reg           <= neg_next;
        bit_cnt_reg       <= bit_cnt_next;
        ndig_reg          <= ndig_next;
        total_reg         <= total_next;
        m_char_code_reg   <= m_char_code_next;
        m_is_last_reg     <= m_is_last_next;
        m_text_length_reg <= m_text_length_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_char_code   = m_char_code_reg;
    assign m_is_last     = m_is_last_reg;
    assign m_text_length = m_text_length_reg;

    `SITDA_ASSERT_NOW(a_mid_len_zero, aclk, aresetn,
        m_valid_reg && !m_is_last_reg, m_text_length_reg == '0,
        "length on a non-final character")
    `SITDA_ASSERT_NOW(a_last_len_range, aclk, aresetn,
        m_valid_reg && m_is_last_reg,
        m_text_length_reg != '0 && m_text_length_reg <= sitda_pkg::LEN_W'(sitda_pkg::DIGITS),
        "final length out of range")
    `SITDA_ASSERT_NOW(a_minus_not_last, aclk, aresetn,
        m_valid_reg && m_char_code_reg == sitda_pkg::CHAR_MINUS, !m_is_last_reg,
        "minus sign flagged as final character")
    `SITDA_ASSERT_NOW(a_digit_count, aclk, aresetn,
        state_reg == ST_DIGIT || state_reg == ST_SIGN, ndig_reg != '0,
        "emitting with no digits left")
    `SITDA_ASSERT_NEXT(a_last_to_idle, aclk, aresetn,
        state_reg == ST_DIGIT && out_load && ndig_reg == sitda_pkg::LEN_W'(1),
        state_reg == ST_IDLE && m_is_last_reg,
        "final digit did not end the number")

endmodule

`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii.sv]
// top level: signed 64-bit integer to decimal ascii characters
// depends on sitda_pkg, sitda_front, sitda_queue, sitda_back
//
// channel  dir  ports                                    meaning
// s_       in   s_valid s_ready s_number                 one number per transaction
// m_       out  m_valid m_ready m_char_code              one character per transaction
//               m_is_last m_text_length
//
// each number leaves the queue, goes through bit-serial double dabble over its 64 bits,
// then leading zero trim, then one character per cycle while m_ready allows (1 to 20)
// so the back stage sets the rate; it takes a new number only after the last character of the one before
// reset is synchronous and active low on aresetn; it empties the queue and the output register
// a stalled m_ready holds the output register; the back stage waits, the front keeps filling
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [63:0]                  s_number,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sitda_pkg::CHAR_W-1:0]             m_char_code,
    output logic                                     m_is_last,
    output logic [sitda_pkg::LEN_W-1:0]              m_text_length
);

    // front to queue
    logic            fq_valid;
    logic            fq_ready;
    sitda_pkg::job_t fq_job;

    // queue to back
    logic            qb_valid;
    logic            qb_ready;
    sitda_pkg::job_t qb_job;

    // sign split and magnitude, one number held
    sitda_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_number  (s_number),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decouples accepting from converting
    sitda_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    // conversion and character output through a registered result stage
    sitda_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (qb_valid),
        .job_ready     (qb_ready),
        .job           (qb_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_is_last     (m_is_last),
        .m_text_length (m_text_length)
    );

endmodule

`default_nettype wire
